// ===== sv/pace_pkg.sv =====
// Shared widths, packet positions and opcodes of the packet ALU command engine.
`timescale 1ns / 1ps

package pace_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 5;

    localparam logic [POS_W-1:0] POS_OPCODE  = 4'd0;
    localparam logic [POS_W-1:0] POS_A_FIRST = 4'd1;
    localparam logic [POS_W-1:0] POS_A_LAST  = 4'd4;
    localparam logic [POS_W-1:0] POS_B_FIRST = 4'd5;
    localparam logic [POS_W-1:0] POS_B_LAST  = 4'd8;
    localparam logic [POS_W-1:0] POS_CHECK   = 4'd9;

    localparam logic [BYTE_W-1:0] OP_ADD = 8'd0;
    localparam logic [BYTE_W-1:0] OP_SUB = 8'd1;
    localparam logic [BYTE_W-1:0] OP_MUL = 8'd2;
    localparam logic [BYTE_W-1:0] OP_DIV = 8'd3;

endpackage

// ===== sv/pace_byte_if.sv =====
// Byte channel and result channel interfaces of the packet ALU command engine.
`timescale 1ns / 1ps

interface pace_byte_if;
    logic                        valid;
    logic                        ready;
    logic [pace_pkg::BYTE_W-1:0] data_byte;

    modport source(output valid, output data_byte, input ready);
    modport sink(input valid, input data_byte, output ready);
endinterface

interface pace_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [pace_pkg::WORD_W-1:0] selected_result;
    logic signed [pace_pkg::WORD_W-1:0] sum_result;
    logic signed [pace_pkg::WORD_W-1:0] difference_result;
    logic signed [pace_pkg::WORD_W-1:0] product_result;
    logic signed [pace_pkg::WORD_W-1:0] quotient_result;
    logic        [pace_pkg::BYTE_W-1:0] opcode_seen;
    logic                               bad_opcode;

    modport source(output valid, output selected_result, output sum_result,
                   output difference_result, output product_result,
                   output quotient_result, output opcode_seen, output bad_opcode,
                   input ready);
    modport sink(input valid, input selected_result, input sum_result,
                 input difference_result, input product_result,
                 input quotient_result, input opcode_seen, input bad_opcode,
                 output ready);
endinterface

// ===== sv/packet_alu_command_engine_unit.sv =====
// Packet ALU command engine: packet framing, arithmetic and iterative divider.
`timescale 1ns / 1ps
//
// i_in carries the packet stream one byte per word: opcode, first operand
// (4 bytes, big-endian), second operand (4 bytes, big-endian), checksum.
// The checksum value is ignored; its word ends the packet.
// o_out carries one result word per packet: selected result, sum,
// difference, product, quotient, opcode and bad-opcode flag.
// Bytes 0 to 8 of a packet are taken one per cycle.
// After the checksum word, sum, difference and product are registered and
// a radix-2 restoring divider runs 32 steps, one quotient bit per cycle;
// i_in.ready is low meanwhile. The result is then loaded into the output
// register once that register is free; i_in.ready stays low until then.
// The output register frees the input side: bytes of the next packet are
// taken while a result waits. If the receiver stalls, the next result
// waits in the engine and i_in.ready stays low until the register frees.
// Reset (synchronous, active low) clears the packet position, operands,
// opcode and output valid; the first byte after reset is an opcode.

module packet_alu_command_engine_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pace_byte_if.sink     i_in,
    pace_result_if.source o_out
);

    typedef enum logic [1:0] {
        S_RECV,
        S_DIV,
        S_DONE
    } t_state;

    t_state                        r_state, n_state;
    logic [pace_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [pace_pkg::BYTE_W-1:0]   r_opcode, n_opcode;
    logic [pace_pkg::WORD_W-1:0]   r_op_a, n_op_a;
    logic [pace_pkg::WORD_W-1:0]   r_op_b, n_op_b;
    logic [pace_pkg::WORD_W-1:0]   r_sum, n_sum;
    logic [pace_pkg::WORD_W-1:0]   r_diff, n_diff;
    logic [pace_pkg::WORD_W-1:0]   r_prod, n_prod;
    logic [pace_pkg::WORD_W-1:0]   r_rem, n_rem;
    logic [pace_pkg::WORD_W-1:0]   r_quo, n_quo;
    logic [pace_pkg::WORD_W-1:0]   r_dvs, n_dvs;
    logic                          r_neg, n_neg;
    logic                          r_zero, n_zero;
    logic [pace_pkg::CNT_W-1:0]    r_cnt, n_cnt;

    logic                          r_out_valid, n_out_valid;
    logic [pace_pkg::WORD_W-1:0]   r_out_sel, n_out_sel;
    logic [pace_pkg::WORD_W-1:0]   r_out_sum, n_out_sum;
    logic [pace_pkg::WORD_W-1:0]   r_out_diff, n_out_diff;
    logic [pace_pkg::WORD_W-1:0]   r_out_prod, n_out_prod;
    logic [pace_pkg::WORD_W-1:0]   r_out_quo, n_out_quo;
    logic [pace_pkg::BYTE_W-1:0]   r_out_opcode, n_out_opcode;
    logic                          r_out_bad, n_out_bad;

    logic                          in_acc;
    logic [pace_pkg::WORD_W-1:0]   prod_low;
    logic [pace_pkg::WORD_W:0]     rem_sh;
    logic [pace_pkg::WORD_W:0]     rem_try;
    logic [pace_pkg::WORD_W-1:0]   mag_a;
    logic [pace_pkg::WORD_W-1:0]   mag_b;
    logic [pace_pkg::WORD_W-1:0]   quo_final;

    assign i_in.ready = (r_state == S_RECV);
    assign in_acc     = i_in.valid && (r_state == S_RECV);

    assign prod_low  = r_op_a * r_op_b;
    assign mag_a     = r_op_a[pace_pkg::WORD_W-1] ? (~r_op_a + 1'b1) : r_op_a;
    assign mag_b     = r_op_b[pace_pkg::WORD_W-1] ? (~r_op_b + 1'b1) : r_op_b;
    assign rem_sh    = {r_rem, r_quo[pace_pkg::WORD_W-1]};
    assign rem_try   = rem_sh - {1'b0, r_dvs};
    assign quo_final = r_zero ? '0 : (r_neg ? (~r_quo + 1'b1) : r_quo);

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_opcode     = r_opcode;
        n_op_a       = r_op_a;
        n_op_b       = r_op_b;
        n_sum        = r_sum;
        n_diff       = r_diff;
        n_prod       = r_prod;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_dvs        = r_dvs;
        n_neg        = r_neg;
        n_zero       = r_zero;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_out_sel    = r_out_sel;
        n_out_sum    = r_out_sum;
        n_out_diff   = r_out_diff;
        n_out_prod   = r_out_prod;
        n_out_quo    = r_out_quo;
        n_out_opcode = r_out_opcode;
        n_out_bad    = r_out_bad;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_RECV: begin
                if (in_acc) begin
                    case (r_pos) inside
                        pace_pkg::POS_OPCODE: begin
                            n_opcode = i_in.data_byte;
                            n_pos    = r_pos + 1'b1;
                        end
                        [pace_pkg::POS_A_FIRST:pace_pkg::POS_A_LAST]: begin
                            n_op_a = {r_op_a[pace_pkg::WORD_W-pace_pkg::BYTE_W-1:0],
                                      i_in.data_byte};
                            n_pos  = r_pos + 1'b1;
                        end
                        [pace_pkg::POS_B_FIRST:pace_pkg::POS_B_LAST]: begin
                            n_op_b = {r_op_b[pace_pkg::WORD_W-pace_pkg::BYTE_W-1:0],
                                      i_in.data_byte};
                            n_pos  = r_pos + 1'b1;
                        end
                        default: begin
                            n_pos   = pace_pkg::POS_OPCODE;
                            n_sum   = r_op_a + r_op_b;
                            n_diff  = r_op_a - r_op_b;
                            n_prod  = prod_low;
                            n_rem   = '0;
                            n_quo   = mag_a;
                            n_dvs   = mag_b;
                            n_neg   = r_op_a[pace_pkg::WORD_W-1] ^ r_op_b[pace_pkg::WORD_W-1];
                            n_zero  = (r_op_b == '0);
                            n_cnt   = '0;
                            n_state = S_DIV;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (!rem_try[pace_pkg::WORD_W]) begin
                    n_rem = rem_try[pace_pkg::WORD_W-1:0];
                    n_quo = {r_quo[pace_pkg::WORD_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[pace_pkg::WORD_W-1:0];
                    n_quo = {r_quo[pace_pkg::WORD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sum    = r_sum;
                    n_out_diff   = r_diff;
                    n_out_prod   = r_prod;
                    n_out_quo    = quo_final;
                    n_out_opcode = r_opcode;
                    n_out_bad    = 1'b0;
                    case (r_opcode)
                        pace_pkg::OP_ADD: n_out_sel = r_sum;
                        pace_pkg::OP_SUB: n_out_sel = r_diff;
                        pace_pkg::OP_MUL: n_out_sel = r_prod;
                        pace_pkg::OP_DIV: n_out_sel = quo_final;
                        default: begin
                            n_out_sel = '0;
                            n_out_bad = 1'b1;
                        end
                    endcase
                    n_state = S_RECV;
                end
            end
            default: n_state = S_RECV;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RECV;
            r_pos       <= pace_pkg::POS_OPCODE;
            r_opcode    <= '0;
            r_op_a      <= '0;
            r_op_b      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_opcode    <= n_opcode;
            r_op_a      <= n_op_a;
            r_op_b      <= n_op_b;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_sum        <= n_sum;
        r_diff       <= n_diff;
        r_prod       <= n_prod;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_dvs        <= n_dvs;
        r_neg        <= n_neg;
        r_zero       <= n_zero;
        r_out_sel    <= n_out_sel;
        r_out_sum    <= n_out_sum;
        r_out_diff   <= n_out_diff;
        r_out_prod   <= n_out_prod;
        r_out_quo    <= n_out_quo;
        r_out_opcode <= n_out_opcode;
        r_out_bad    <= n_out_bad;
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.selected_result   = $signed(r_out_sel);
    assign o_out.sum_result        = $signed(r_out_sum);
    assign o_out.difference_result = $signed(r_out_diff);
    assign o_out.product_result    = $signed(r_out_prod);
    assign o_out.quotient_result   = $signed(r_out_quo);
    assign o_out.opcode_seen       = r_out_opcode;
    assign o_out.bad_opcode        = r_out_bad;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= pace_pkg::POS_CHECK)
        else $error("packet position out of range");

    a_check_stalls_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (r_pos >= pace_pkg::POS_CHECK)) |=> !i_in.ready)
        else $error("input taken during division");

    a_bad_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_bad == (r_out_opcode > pace_pkg::OP_DIV)))
        else $error("bad opcode flag does not match opcode");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_sel == '0))
        else $error("selected result not zero on bad opcode");

endmodule
